// ----- design/rass_pkg.sv -----
// Shared types and status codes for the return address shadow stack.
`timescale 1ns / 1ps

package rass_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned DepthW = 9;

  // Event kind carried by an input transfer
  localparam logic ACT_CALL   = 1'b0;
  localparam logic ACT_RETURN = 1'b1;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_MATCH     = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4
  } rass_status_e;

  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] address;
  } rass_in_t;

  typedef struct packed {
    rass_status_e      status;
    logic [AddrW-1:0]  expected_address;
    logic [DepthW-1:0] depth;
  } rass_out_t;

endpackage

// ----- design/rass_mem.sv -----
// Single-port-write, single-port-read stack memory with registered read data.
`timescale 1ns / 1ps

module rass_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 64,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  // Read one entry, data appears the next cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/return_address_shadow_stack.sv -----
// Top level of the return address shadow stack: control, count and result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid_i/in_ready_o   | rass_in_t  (action, address)
//   out     | output    | out_valid_o/out_ready_i | rass_out_t (status, expected, depth)
//
// A call, an overflow and an underflow have their result registered at the accepting
// edge. A return that pops first reads the stack memory, whose read data is registered,
// and registers its result in the read state; no new transfer is taken during the read.
// A new transfer is taken while the result register is empty or being emptied.
// Reset clears the depth count and the control state; the memory holds no reset value.
// A stalled output holds its result and blocks further input transfers.
`timescale 1ns / 1ps

module return_address_shadow_stack
  import rass_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rass_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rass_out_t out_data_o
);

  localparam int unsigned IdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  count_q;
  logic [AddrW-1:0] target_q;
  logic             out_valid_q;
  rass_out_t        out_data_q;

  logic             in_xfer;
  logic             is_return;
  logic             empty;
  logic             full;
  logic             push;
  logic             pop;
  logic             out_valid_d;
  logic [CntW-1:0]  count_dec;
  logic [AddrW-1:0] rd_data;
  logic [CntW+DepthW-1:0] depth_wide;

  // Decode the incoming event
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_return  = (in_data_i.action == ACT_RETURN);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntFull);
  assign push       = in_xfer && !is_return && !full;
  assign pop        = in_xfer && is_return && !empty;
  assign count_dec  = count_q - CntOne;

  // Set the result flag on a new result, drop it once transferred
  assign out_valid_d = ((state_q == S_READ) || (in_xfer && !pop)) ? 1'b1 :
                       (out_valid_q && !out_ready_i);

  rass_mem #(
    .Depth (STACK_DEPTH),
    .Width (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (push),
    .wr_idx_i  (count_q[IdxW-1:0]),
    .wr_data_i (in_data_i.address),
    .rd_en_i   (pop),
    .rd_idx_i  (count_dec[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  // Reported depth is the count modulo 512
  always_comb begin
    depth_wide = '0;
    unique case (state_q)
      S_IDLE: begin
        if (push) begin
          depth_wide = {{DepthW{1'b0}}, count_q + CntOne};
        end else begin
          depth_wide = {{DepthW{1'b0}}, count_q};
        end
      end
      S_READ: depth_wide = {{DepthW{1'b0}}, count_q};
      default: depth_wide = '0;
    endcase
  end

  // Hold state, count and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      target_q    <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (pop) begin
              count_q  <= count_dec;
              target_q <= in_data_i.address;
              state_q  <= S_READ;
            end else begin
              out_data_q.expected_address <= '0;
              out_data_q.depth            <= depth_wide[DepthW-1:0];
              if (is_return) begin
                out_data_q.status <= ST_UNDERFLOW;
              end else if (full) begin
                out_data_q.status <= ST_OVERFLOW;
              end else begin
                out_data_q.status <= ST_PUSHED;
                count_q           <= count_q + CntOne;
              end
            end
          end
        end
        S_READ: begin
          // Compare the popped entry with the actual target
          out_data_q.expected_address <= rd_data;
          out_data_q.depth            <= depth_wide[DepthW-1:0];
          out_data_q.status           <= (rd_data == target_q) ? ST_MATCH : ST_MISMATCH;
          state_q                     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The count never passes the stack size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("stack count above capacity");

  // A pop always moves to the read state
  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (state_q == S_READ))
    else $error("pop did not start a memory read");

  // The result register is free while a read is in flight
  a_read_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !out_valid_q)
    else $error("result register busy during read");

  // A read always delivers a compare result next cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (out_valid_q &&
      (out_data_q.status == ST_MATCH || out_data_q.status == ST_MISMATCH)))
    else $error("read did not produce a compare result");

  // A push grows the count by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (count_q == $past(count_q) + CntOne))
    else $error("push did not advance the count");

endmodule

// ----- test/return_address_shadow_stack_tb.sv -----
// Self-checking testbench for the return address shadow stack.
`timescale 1ns / 1ps

module return_address_shadow_stack_tb;
  import rass_pkg::*;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned MAX_REPORTS = 10;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  rass_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  rass_out_t out_data_o;

  // Shadow copy of the stack and the verdicts still owed by the block
  logic [AddrW-1:0] shadow_mem [STACK_DEPTH];
  int unsigned      stack_level;
  rass_out_t        pending_verdicts [$];

  bit          idle_en;
  int unsigned hold_request;
  int unsigned error_count;
  int unsigned n_push, n_match, n_mismatch, n_under, n_over;

  return_address_shadow_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Compute the verdict for one event and advance the shadow stack
  function automatic rass_out_t predict_return_check(input rass_in_t item);
    rass_out_t res;
    res.expected_address = '0;
    if (item.action == ACT_CALL) begin
      if (stack_level >= STACK_DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        shadow_mem[stack_level] = item.address;
        stack_level++;
        res.status = ST_PUSHED;
      end
    end else if (stack_level == 0) begin
      res.status = ST_UNDERFLOW;
    end else begin
      stack_level--;
      res.expected_address = shadow_mem[stack_level];
      res.status = (shadow_mem[stack_level] == item.address) ? ST_MATCH : ST_MISMATCH;
    end
    res.depth = DepthW'(stack_level);
    return res;
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Offer one event, hold it until the transfer, then record its verdict
  task automatic send_event(input logic act, input logic [AddrW-1:0] addr);
    rass_in_t  item;
    rass_out_t verdict;
    int unsigned gap;
    item.action  = act;
    item.address = addr;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    verdict = predict_return_check(item);
    pending_verdicts.push_back(verdict);
    case (verdict.status)
      ST_PUSHED:    n_push++;
      ST_MATCH:     n_match++;
      ST_MISMATCH:  n_mismatch++;
      ST_UNDERFLOW: n_under++;
      default:      n_over++;
    endcase
  endtask

  // Return to the top entry with a chance of match_pct percent, else to a corrupted target
  task automatic send_return(input int unsigned match_pct);
    logic [AddrW-1:0] target;
    if (stack_level == 0) begin
      target = rand_addr();
    end else if ($urandom_range(0, 99) < match_pct) begin
      target = shadow_mem[stack_level-1];
    end else if ($urandom_range(0, 1) == 0) begin
      target = shadow_mem[stack_level-1] ^ (64'd1 << $urandom_range(0, 63));
    end else begin
      target = rand_addr();
    end
    send_event(ACT_RETURN, target);
  endtask

  task automatic report_error(input string what, input rass_out_t want, input rass_out_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("tb: %s at %0t: exp status %0d addr %h depth %0d, got status %0d addr %h depth %0d",
               what, $time, want.status, want.expected_address, want.depth,
               got.status, got.expected_address, got.depth);
    end
  endtask

  // Compare each result transfer with the oldest verdict owed
  always @(posedge clk_i) begin : check_results
    rass_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        want = '0;
        report_error("result with nothing pending", want, out_data_o);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data_o.status !== want.status ||
            out_data_o.expected_address !== want.expected_address ||
            out_data_o.depth !== want.depth) begin
          report_error("mismatch", want, out_data_o);
        end
      end
    end
  end

  // Drive the output ready: random stalls plus an occasional long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        hold_left   = $urandom_range(1, 19) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // End the run when no transfer happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("tb: no transfer for %0d cycles", IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Extremes, every status code but overflow, nesting and both empty-stack cases
  task automatic test_directed();
    send_event(ACT_RETURN, '1);
    send_event(ACT_RETURN, '0);
    send_event(ACT_CALL, '0);
    send_event(ACT_RETURN, '0);
    send_event(ACT_CALL, '1);
    send_event(ACT_RETURN, '1);
    send_event(ACT_CALL, 64'h8000_0000_0000_0000);
    send_event(ACT_RETURN, 64'h7FFF_FFFF_FFFF_FFFF);
    send_event(ACT_CALL, 64'h0000_0000_0040_1000);
    send_event(ACT_CALL, 64'h0000_7FFF_DEAD_BEEF);
    send_event(ACT_CALL, 64'hFFFF_FFFF_8000_0004);
    send_event(ACT_RETURN, 64'hFFFF_FFFF_8000_0004);
    send_event(ACT_RETURN, 64'h0000_7FFF_DEAD_BEEE);
    send_event(ACT_RETURN, 64'h0000_0000_0040_1000);
    send_event(ACT_RETURN, 64'h0000_0000_0040_1000);
    send_event(ACT_CALL, 64'h5555_5555_5555_5555);
    send_event(ACT_RETURN, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  // Fill the stack, push past the top, then unwind it completely
  task automatic test_fill_and_drain();
    while (stack_level < STACK_DEPTH) send_event(ACT_CALL, rand_addr());
    repeat (3) send_event(ACT_CALL, rand_addr());
    send_return(50);
    send_event(ACT_CALL, rand_addr());
    send_event(ACT_CALL, rand_addr());
    while (stack_level != 0) send_return(92);
    send_return(100);
  endtask

  // Hold the sink off while events keep coming so the input stalls
  task automatic test_backpressure();
    hold_request = LONG_HOLD;
    repeat (30) begin
      if (stack_level == 0 || $urandom_range(0, 1) == 0) send_event(ACT_CALL, rand_addr());
      else send_return(85);
    end
  endtask

  // Mostly balanced call/return nesting with random targets and some noise
  task automatic test_random_nesting(input int unsigned n_events);
    int unsigned call_pct;
    repeat (n_events) begin
      if (stack_level == 0) call_pct = 85;
      else if (stack_level >= STACK_DEPTH) call_pct = 20;
      else if (stack_level < 16) call_pct = 62;
      else call_pct = 50;
      if ($urandom_range(0, 99) < call_pct) send_event(ACT_CALL, rand_addr());
      else send_return(88);
    end
  endtask

  initial begin : run_tests
    int unsigned drain_cycles;
    stack_level  = 0;
    hold_request = 0;
    error_count  = 0;
    idle_en      = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random_nesting(1150);
    idle_en = 1'b0;
    test_random_nesting(200);
    in_valid_i <= 1'b0;

    // Wait for every owed verdict, then a short tail
    drain_cycles = 0;
    while (pending_verdicts.size() != 0 && drain_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (5) @(posedge clk_i);

    $display("tb: %0d pushes, %0d matched and %0d mismatched returns", n_push, n_match,
             n_mismatch);
    $display("tb: %0d underflows, %0d refused pushes, %0d results left", n_under, n_over,
             pending_verdicts.size());
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
